// ===== src/rbb_pkg.sv =====
// Package for the RGB 3x3 box blur unit: widths, codes, pixel type and the
// divide-by-nine constants. No dependencies.
package rbb_pkg;

    localparam int COLOR_W = 8;
    localparam int PIX_W = 3 * COLOR_W;
    localparam int LINE_W = 2 * PIX_W;
    localparam int ROW_W = 12;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE = 3;
    localparam int RESET_WIDTH = 100;
    localparam int RESET_HEIGHT = 100;

    // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
    localparam int COLSUM_W = 10;
    localparam int SUM_W = 12;
    localparam int DIV9_MUL_W = 13;
    localparam int DIV9_MUL = 7282;
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic
    {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } command_t;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } pixel_t;

    typedef struct packed
    {
        logic   frame_end;
        pixel_t pixel;
    } result_t;

endpackage

// ===== src/rbb_ram.sv =====
// Generic simple dual-port RAM with registered read, one write and one read
// port. Depends on rbb_pkg for default sizes.
module rbb_ram #(
    parameter int WIDTH = rbb_pkg::LINE_W,
    parameter int DEPTH = rbb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rgb_box_blur_3x3_unit.sv =====
// Top level of the RGB 3x3 box blur unit: position control, line store,
// window column sums, divide by nine and output queue. Uses rbb_pkg, rbb_ram.
//
// Takes one pixel or flush transaction per clock while the output queue has
// room, and gives one result per clock when the output side is ready. A result
// for pixel n leaves with input pixel n+W+1 (W = frame_width); the last W+1
// results of a frame are drained with flush transactions. Each transaction
// reaches the output queue through the line-store read, the window column
// sums, and the nine-term add with the divide by nine. The line store is a
// single RAM of MAX_WIDTH words holding the two previous rows, read and
// rewritten in the next cycle, with a bypass for back-to-back use of one column;
// it needs no clearing after reset. A four-entry output queue lets input
// continue while results wait. Writing either size register restarts the frame.
module rgb_box_blur_3x3_unit #(
    parameter int MAX_WIDTH = rbb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rbb_pkg::PIX_W-1:0]     s_tdata,   // red_in, green_in, blue_in
    input  logic                          s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rbb_pkg::PIX_W-1:0]     m_tdata,   // red_out, green_out, blue_out
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);
    localparam int RESET_W_EFF = (rbb_pkg::RESET_WIDTH > MAX_WIDTH) ?
                                 MAX_WIDTH : rbb_pkg::RESET_WIDTH;
    localparam int ROW_W = rbb_pkg::ROW_W;
    localparam int CW = rbb_pkg::COLOR_W;

    // frame size, kept as W-1, W+1 and H-1
    logic [COL_W-1:0]  wm1_reg, wm1_next;
    logic [PEND_W-1:0] wp1_reg, wp1_next;
    logic [ROW_W-1:0]  hm1_reg, hm1_next;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic cfg_write;
    logic accept;
    logic is_flush;
    logic at_start;
    logic drop;
    logic fire;
    logic [COL_W-1:0]  oc_eff;
    logic [ROW_W-1:0]  or_eff;
    logic [PEND_W-1:0] pend_eff;
    logic col_last;
    logic row_last;
    logic [COL_W-1:0] rd_addr;

    // stage 1: line-store read
    logic s1_pix_reg, s1_res_reg;
    logic s1_border_reg, s1_end_reg, s1_sel_lower_reg, s1_fwd_reg;
    logic [COL_W-1:0] s1_addr_reg;
    rbb_pkg::pixel_t s1_px_reg;
    logic [rbb_pkg::LINE_W-1:0] s1_fwd_data_reg;

    logic [rbb_pkg::LINE_W-1:0] ram_rd_data;
    logic [rbb_pkg::LINE_W-1:0] line_data;
    logic [rbb_pkg::LINE_W-1:0] ram_wr_data;
    rbb_pkg::pixel_t upper_px, lower_px, s1_orig;

    // window: column sums per channel and the middle pixel of the newest column
    logic [rbb_pkg::COLSUM_W-1:0] cs_reg [3][3];
    logic [rbb_pkg::COLSUM_W-1:0] new_cs [3];
    rbb_pkg::pixel_t mid_reg;

    // stage 2: sum and divide
    logic s2_res_reg, s2_border_reg, s2_end_reg;
    rbb_pkg::pixel_t s2_orig_reg;
    rbb_pkg::pixel_t s2_blur;
    rbb_pkg::result_t s2_result;
    logic [rbb_pkg::SUM_W-1:0]  sum9 [3];
    logic [rbb_pkg::PROD_W-1:0] prod [3];

    // output queue
    rbb_pkg::result_t fifo_reg [rbb_pkg::FIFO_DEPTH];
    logic [rbb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rbb_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [rbb_pkg::FIFO_CNT_W-1:0] occupancy;
    logic pop;
    rbb_pkg::result_t head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_comb
    begin
        int wv;
        int hv;
        wv = int'(cfg_data[rbb_pkg::WIDTH_REG_W-1:0]);
        hv = int'(cfg_data[rbb_pkg::HEIGHT_REG_W-1:0]);
        if (wv < rbb_pkg::MIN_SIZE)
        begin
            wv = rbb_pkg::MIN_SIZE;
        end
        else if (wv > MAX_WIDTH)
        begin
            wv = MAX_WIDTH;
        end
        if (hv < rbb_pkg::MIN_SIZE)
        begin
            hv = rbb_pkg::MIN_SIZE;
        end
        else if (hv > rbb_pkg::MAX_HEIGHT)
        begin
            hv = rbb_pkg::MAX_HEIGHT;
        end
        wm1_next = wm1_reg;
        wp1_next = wp1_reg;
        hm1_next = hm1_reg;
        if (cfg_write)
        begin
            unique case (rbb_pkg::cfg_index_t'(cfg_index))
                rbb_pkg::REG_FRAME_WIDTH:
                begin
                    wm1_next = COL_W'(wv - 1);
                    wp1_next = PEND_W'(wv + 1);
                end
                rbb_pkg::REG_FRAME_HEIGHT:
                begin
                    hm1_next = ROW_W'(hv - 1);
                end
                default:
                begin
                    wm1_next = wm1_reg;
                end
            endcase
        end
    end

    assign occupancy = cnt_reg + rbb_pkg::FIFO_CNT_W'(s1_res_reg)
                       + rbb_pkg::FIFO_CNT_W'(s2_res_reg);
    assign s_tready = occupancy < rbb_pkg::FIFO_CNT_W'(rbb_pkg::FIFO_DEPTH);
    assign accept = s_tvalid & s_tready;
    assign is_flush = (rbb_pkg::command_t'(s_tuser) == rbb_pkg::CMD_FLUSH);
    assign at_start = (in_col_reg == '0) && (in_row_reg == '0);
    assign drop = !is_flush && at_start && (pend_reg != '0);
    assign oc_eff = drop ? '0 : out_col_reg;
    assign or_eff = drop ? '0 : out_row_reg;
    assign pend_eff = drop ? '0 : pend_reg;
    assign fire = is_flush ? (at_start && (pend_reg != '0)) : (pend_eff >= wp1_reg);
    assign col_last = oc_eff >= wm1_reg;
    assign row_last = or_eff >= hm1_reg;
    assign rd_addr = is_flush ? out_col_reg : in_col_reg;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next = pend_reg;
        if (cfg_write)
        begin
            in_col_next = '0;
            in_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next = '0;
        end
        else if (accept)
        begin
            if (!is_flush)
            begin
                if (in_col_reg >= wm1_reg)
                begin
                    in_col_next = '0;
                    in_row_next = (in_row_reg >= hm1_reg) ? '0 : in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            out_col_next = oc_eff;
            out_row_next = or_eff;
            pend_next = pend_eff;
            if (fire)
            begin
                if (col_last)
                begin
                    out_col_next = '0;
                    out_row_next = row_last ? '0 : or_eff + 1'b1;
                end
                else
                begin
                    out_col_next = oc_eff + 1'b1;
                end
                if (is_flush)
                begin
                    pend_next = pend_reg - 1'b1;
                end
            end
            else if (!is_flush)
            begin
                pend_next = pend_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg <= COL_W'(RESET_W_EFF - 1);
            wp1_reg <= PEND_W'(RESET_W_EFF + 1);
            hm1_reg <= ROW_W'(rbb_pkg::RESET_HEIGHT - 1);
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg <= '0;
            s1_pix_reg <= 1'b0;
            s1_res_reg <= 1'b0;
            s2_res_reg <= 1'b0;
        end
        else
        begin
            wm1_reg <= wm1_next;
            wp1_reg <= wp1_next;
            hm1_reg <= hm1_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg <= pend_next;
            s1_pix_reg <= accept && !is_flush;
            s1_res_reg <= accept && fire;
            s2_res_reg <= s1_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_border_reg <= (or_eff == '0) || row_last || (oc_eff == '0) || col_last;
            s1_end_reg <= row_last && col_last;
            s1_sel_lower_reg <= out_row_reg >= hm1_reg;
            s1_addr_reg <= rd_addr;
            s1_px_reg <= s_tdata;
            s1_fwd_reg <= s1_pix_reg && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= ram_wr_data;
        end
    end

    rbb_ram #(
        .WIDTH (rbb_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_pix_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign line_data = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;
    assign upper_px = line_data[rbb_pkg::LINE_W-1:rbb_pkg::PIX_W];
    assign lower_px = line_data[rbb_pkg::PIX_W-1:0];
    assign ram_wr_data = {lower_px, s1_px_reg};
    assign s1_orig = s1_pix_reg ? mid_reg : (s1_sel_lower_reg ? lower_px : upper_px);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            new_cs[k] = rbb_pkg::COLSUM_W'(upper_px[k*CW +: CW])
                      + rbb_pkg::COLSUM_W'(lower_px[k*CW +: CW])
                      + rbb_pkg::COLSUM_W'(s1_px_reg[k*CW +: CW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_pix_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cs_reg[0][k] <= cs_reg[1][k];
                cs_reg[1][k] <= cs_reg[2][k];
                cs_reg[2][k] <= new_cs[k];
            end
            mid_reg <= lower_px;
        end
        s2_border_reg <= s1_border_reg;
        s2_end_reg <= s1_end_reg;
        s2_orig_reg <= s1_orig;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum9[k] = rbb_pkg::SUM_W'(cs_reg[0][k]) + rbb_pkg::SUM_W'(cs_reg[1][k])
                    + rbb_pkg::SUM_W'(cs_reg[2][k]);
            prod[k] = rbb_pkg::PROD_W'(sum9[k])
                    * rbb_pkg::PROD_W'(rbb_pkg::DIV9_MUL);
            s2_blur[k*CW +: CW] = prod[k][rbb_pkg::DIV9_SHIFT +: CW];
        end
    end

    assign s2_result.frame_end = s2_end_reg;
    assign s2_result.pixel = s2_border_reg ? s2_orig_reg : s2_blur;

    assign pop = m_tvalid & m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (s2_res_reg && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!s2_res_reg && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (s2_res_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_res_reg)
        begin
            fifo_reg[wr_ptr_reg] <= s2_result;
        end
    end

    assign head = fifo_reg[rd_ptr_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tdata = head.pixel;
    assign m_tlast = head.frame_end;

endmodule

// ===== tb/tb_rgb_box_blur_3x3_unit.sv =====
// Self-checking testbench for rgb_box_blur_3x3_unit: queued pixel and flush
// transactions, a transaction-level blur predictor and an in-order result check.
// Depends on rbb_pkg and the unit's RTL only.
module tb_rgb_box_blur_3x3_unit;

    localparam int LINE_DEPTH = rbb_pkg::DEFAULT_MAX_WIDTH;
    localparam int BLUR_CELLS = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 90;
    localparam int RANDOM_ITEMS = 300;
    localparam int WIDE_PART_ITEMS = 40;

    typedef enum int
    {
        FILL_RANDOM,
        FILL_SATURATED,
        FILL_WHITE,
        FILL_BLACK
    } fill_t;

    typedef struct
    {
        rbb_pkg::command_t cmd;
        rbb_pkg::pixel_t   px;
    } blur_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rbb_pkg::PIX_W-1:0]      s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rbb_pkg::PIX_W-1:0]      m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_index = 1'b0;
    logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rgb_box_blur_3x3_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    rbb_pkg::pixel_t  line_a [LINE_DEPTH];   // two rows back
    rbb_pkg::pixel_t  line_b [LINE_DEPTH];   // one row back
    rbb_pkg::pixel_t  nbhd [3][3];
    int unsigned      fw, fh;
    int unsigned      x_in, y_in, x_out, y_out;
    int unsigned      backlog;

    blur_item_t       pixel_feed [$];
    rbb_pkg::result_t blurred_due [$];
    blur_item_t       on_bus;
    bit               bus_busy;
    rbb_pkg::result_t step_out;
    rbb_pkg::result_t due_px;
    rbb_pkg::pixel_t  seen_px;

    int               src_idle_pct, snk_idle_pct;
    int               src_gap, snk_gap, hold_left;
    bit               hold_armed, hold_done;
    int               errors;
    int unsigned      queued_items;
    int unsigned      frame_pos;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic void blur_reset();
        fw = rbb_pkg::RESET_WIDTH;
        fh = rbb_pkg::RESET_HEIGHT;
        foreach (line_a[i])
        begin
            line_a[i] = '0;
            line_b[i] = '0;
        end
        foreach (nbhd[i, j])
            nbhd[i][j] = '0;
        x_in = 0; y_in = 0; x_out = 0; y_out = 0; backlog = 0;
    endfunction

    function automatic void blur_cfg(rbb_pkg::cfg_index_t idx,
                                     logic [rbb_pkg::CFG_DATA_W-1:0] val);
        if (idx == rbb_pkg::REG_FRAME_WIDTH)
            fw = fit(val[rbb_pkg::WIDTH_REG_W-1:0], rbb_pkg::MIN_SIZE, LINE_DEPTH);
        else
            fh = fit(val, rbb_pkg::MIN_SIZE, rbb_pkg::MAX_HEIGHT);
        x_in = 0; y_in = 0; x_out = 0; y_out = 0; backlog = 0;
    endfunction

    // result for the pixel at (y_out, x_out); border pixels pass through
    function automatic rbb_pkg::result_t blur_emit(rbb_pkg::pixel_t orig);
        rbb_pkg::result_t r;
        bit               on_border;
        int unsigned      s_r, s_g, s_b;
        on_border = y_out == 0 || y_out >= fh - 1 || x_out == 0 || x_out >= fw - 1;
        s_r = 0; s_g = 0; s_b = 0;
        if (on_border)
            r.pixel = orig;
        else
        begin
            foreach (nbhd[i, j])
            begin
                s_r += nbhd[i][j].red;
                s_g += nbhd[i][j].green;
                s_b += nbhd[i][j].blue;
            end
            r.pixel.red   = 8'(s_r / BLUR_CELLS);
            r.pixel.green = 8'(s_g / BLUR_CELLS);
            r.pixel.blue  = 8'(s_b / BLUR_CELLS);
        end
        r.frame_end = y_out >= fh - 1 && x_out >= fw - 1;
        if (x_out >= fw - 1)
        begin
            x_out = 0;
            y_out = (y_out >= fh - 1) ? 0 : y_out + 1;
        end
        else
            x_out++;
        return r;
    endfunction

    function automatic bit blur_step(blur_item_t it, output rbb_pkg::result_t r);
        bit              at_top, fire, first_col;
        int unsigned     col;
        rbb_pkg::pixel_t wrap;
        r = '0;
        at_top = x_in == 0 && y_in == 0;
        if (it.cmd == rbb_pkg::CMD_FLUSH)
        begin
            if (!at_top || backlog == 0)
                return 1'b0;
            backlog--;
            r = blur_emit((y_out >= fh - 1) ? line_b[x_out] : line_a[x_out]);
            return 1'b1;
        end
        if (at_top && backlog != 0)
        begin
            x_out = 0; y_out = 0; backlog = 0;
        end
        col = x_in;
        wrap = line_a[fw - 1];
        for (int i = 0; i < 3; i++)
        begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = line_a[col];
        nbhd[1][2] = line_b[col];
        nbhd[2][2] = it.px;
        line_a[col] = line_b[col];
        line_b[col] = it.px;
        fire = backlog >= fw + 1;
        first_col = x_in == 0;
        if (x_in >= fw - 1)
        begin
            x_in = 0;
            y_in = (y_in >= fh - 1) ? 0 : y_in + 1;
        end
        else
            x_in++;
        if (!fire)
        begin
            backlog++;
            return 1'b0;
        end
        r = blur_emit(first_col ? wrap : nbhd[1][1]);
        return 1'b1;
    endfunction

    task automatic flag_field(string fname, int unsigned want, int unsigned got);
        errors++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, fname, want, got);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                bus_busy = 1'b0;
                if (blur_step(on_bus, step_out))
                    blurred_due.push_back(step_out);
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_feed.size() != 0 && $urandom_range(0, 99) < src_idle_pct)
                begin
                    src_gap = $urandom_range(0, 13);
                    s_tvalid <= 1'b0;
                end
                else if (pixel_feed.size() != 0)
                begin
                    on_bus = pixel_feed.pop_front();
                    bus_busy = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata <= on_bus.px;
                    s_tuser <= on_bus.cmd;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_px = m_tdata;
                if (blurred_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    due_px = blurred_due.pop_front();
                    if (seen_px.red !== due_px.pixel.red)
                        flag_field("red", due_px.pixel.red, seen_px.red);
                    if (seen_px.green !== due_px.pixel.green)
                        flag_field("green", due_px.pixel.green, seen_px.green);
                    if (seen_px.blue !== due_px.pixel.blue)
                        flag_field("blue", due_px.pixel.blue, seen_px.blue);
                    if (m_tlast !== due_px.frame_end)
                        flag_field("frame_end", due_px.frame_end, m_tlast);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < snk_idle_pct)
            begin
                snk_gap = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixel_feed.size() != 0 || bus_busy || blurred_due.size() != 0);
    endtask

    task automatic write_reg(rbb_pkg::cfg_index_t idx,
                             logic [rbb_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        blur_cfg(idx, val);
        frame_pos = 0;
    endtask

    task automatic queue_pixels(int unsigned n, fill_t fill, bit noisy);
        blur_item_t  it;
        logic [31:0] bits;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
            begin
                it.cmd = rbb_pkg::CMD_FLUSH;
                it.px = 24'($urandom);
                pixel_feed.push_back(it);
            end
            bits = $urandom;
            it.cmd = rbb_pkg::CMD_PIXEL;
            case (fill)
                FILL_SATURATED:
                begin
                    it.px.red   = {8{bits[0]}};
                    it.px.green = {8{bits[1]}};
                    it.px.blue  = {8{bits[2]}};
                end
                FILL_WHITE: it.px = '1;
                FILL_BLACK: it.px = '0;
                default:    it.px = bits[rbb_pkg::PIX_W-1:0];
            endcase
            pixel_feed.push_back(it);
        end
        frame_pos = (frame_pos + n) % (fw * fh);
        queued_items += n;
    endtask

    task automatic queue_flushes(int unsigned n);
        blur_item_t it;
        it.cmd = rbb_pkg::CMD_FLUSH;
        repeat (n)
        begin
            it.px = 24'($urandom);
            pixel_feed.push_back(it);
        end
        queued_items += n;
    endtask

    initial
    begin
        int unsigned n_px, n_fl, kind, phase, remaining, w_val, h_val;
        fill_t       fill;
        blur_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 frames: clamped sizes, full-scale sums, flush mid-frame,
        // flush with nothing pending, frame dropped by the next frame
        write_reg(rbb_pkg::REG_FRAME_WIDTH, 13'd0);
        write_reg(rbb_pkg::REG_FRAME_HEIGHT, 13'd2);
        queue_pixels(5, FILL_WHITE, 1'b0);
        queue_flushes(1);
        queue_pixels(4, FILL_WHITE, 1'b0);
        queue_flushes(fw + 2);
        queue_pixels(9, FILL_BLACK, 1'b0);
        queue_flushes(1);

        queued_items = 0;
        phase = 0;
        while (queued_items < RANDOM_ITEMS)
        begin
            src_idle_pct = 10 * $urandom_range(0, 3);
            snk_idle_pct = 10 * $urandom_range(0, 3);
            if (phase != 0)
            begin
                w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 12);
                h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 8);
                if ($urandom_range(0, 1))
                begin
                    write_reg(rbb_pkg::REG_FRAME_WIDTH, rbb_pkg::CFG_DATA_W'(w_val));
                    write_reg(rbb_pkg::REG_FRAME_HEIGHT, rbb_pkg::CFG_DATA_W'(h_val));
                end
                else
                begin
                    write_reg(rbb_pkg::REG_FRAME_HEIGHT, rbb_pkg::CFG_DATA_W'(h_val));
                    write_reg(rbb_pkg::REG_FRAME_WIDTH, rbb_pkg::CFG_DATA_W'(w_val));
                end
            end
            repeat ($urandom_range(1, 3))
            begin
                fill = ($urandom_range(0, 3) == 0) ? FILL_SATURATED : FILL_RANDOM;
                kind = $urandom_range(0, 9);
                remaining = fw * fh - frame_pos;
                n_px = (kind == 0 && remaining > 1) ? $urandom_range(1, remaining - 1)
                                                   : remaining;
                n_fl = (kind == 0) ? 0 :
                       (kind == 1) ? $urandom_range(0, fw) :
                       (kind == 2) ? fw + 1 + $urandom_range(1, 3) : fw + 1;
                if (kind == 3)
                begin
                    queue_pixels(n_px / 2, fill, 1'b1);
                    wait_drained();
                    queue_pixels(n_px - n_px / 2, fill, 1'b1);
                end
                else
                    queue_pixels(n_px, fill, 1'b1);
                queue_flushes(n_fl);
            end
            phase++;
        end

        // widest setting (clamped) with a partial frame, tallest setting,
        // then a long receiver hold
        src_idle_pct = 20;
        snk_idle_pct = 20;
        write_reg(rbb_pkg::REG_FRAME_WIDTH, '1);
        write_reg(rbb_pkg::REG_FRAME_HEIGHT, 13'd3);
        queue_pixels(WIDE_PART_ITEMS, FILL_RANDOM, 1'b0);
        write_reg(rbb_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(rbb_pkg::REG_FRAME_HEIGHT, '1);
        queue_pixels(60, FILL_SATURATED, 1'b0);

        write_reg(rbb_pkg::REG_FRAME_HEIGHT, 13'd20);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_pixels(fw * fh, FILL_RANDOM, 1'b0);
        queue_flushes(fw + 1);
        hold_armed = 1'b1;

        write_reg(rbb_pkg::REG_FRAME_WIDTH,
                  rbb_pkg::CFG_DATA_W'($urandom_range(3, 12)));
        write_reg(rbb_pkg::REG_FRAME_HEIGHT,
                  rbb_pkg::CFG_DATA_W'($urandom_range(3, 8)));
        queue_pixels(fw * fh, FILL_RANDOM, 1'b0);
        queue_flushes(fw + 1);

        for (int i = 0; i < 50000; i++)
        begin
            if (pixel_feed.size() == 0 && !bus_busy && blurred_due.size() == 0)
                break;
            @(posedge clk);
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (blurred_due.size() != 0)
        begin
            errors++;
            $display("%0t blur results missing: %0d still expected", $time,
                     blurred_due.size());
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #7200000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rbb_pkg.sv
src/rbb_ram.sv
src/rgb_box_blur_3x3_unit.sv
tb/tb_rgb_box_blur_3x3_unit.sv
